// ===== src/alif_pkg.sv =====
// Shared constants, codes and types for the adaptive LIF neuron step block.
// Used by the channel interfaces and by every module under src.
package alif_pkg;

  // Window of past potentials and the sample count that turns on homeostasis.
  localparam int unsigned WINDOW_LEN  = 100;
  localparam int unsigned MIN_SAMPLES = 10;
  localparam int unsigned PTR_W       = $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W      = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W       = 33 + $clog2(WINDOW_LEN);

  // Field and register widths.
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned Q_W        = 31;
  localparam int unsigned LEAK_W     = 17;
  localparam int unsigned STEP_W     = 20;
  localparam int unsigned KICK_W     = 31;
  localparam int unsigned BASE_W     = 31;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Q16.16 constants.
  localparam int unsigned FRAC        = 16;
  localparam int unsigned ONE_Q       = 65536;
  localparam int unsigned TENTH_Q     = 6554;
  localparam int unsigned HUNDREDTH_Q = 655;
  localparam logic [Q_W-1:0] MAX_Q    = {Q_W{1'b1}};

  // Register reset values.
  localparam int unsigned LEAK_RST = 6554;
  localparam int unsigned STEP_RST = 65536;
  localparam int unsigned KICK_RST = 6554;
  localparam int unsigned BASE_RST = 65536;

  // Shared multiplier: signed A x signed B, full product.
  localparam int unsigned MA_W  = 33;
  localparam int unsigned MB_W  = 24;
  localparam int unsigned MP_W  = MA_W + MB_W;
  localparam int unsigned PFL_W = MP_W - FRAC;          // product after floor shift
  localparam int unsigned SCL_W = LEAK_W + STEP_W - FRAC; // scaled rate*dt

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAK       = 4'd0,
    CFG_TIME_STEP  = 4'd1,
    CFG_ADAPT_KICK = 4'd2,
    CFG_BASE_THR   = 4'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAK_MUL,
    ST_LEAK_FAC,
    ST_POT_MUL,
    ST_POT_SUM,
    ST_FIRE,
    ST_DEC_MUL,
    ST_DEC_FAC,
    ST_ADAPT_MUL,
    ST_ADAPT,
    ST_DIV_WAIT,
    ST_ERR,
    ST_ERR_MUL,
    ST_THR,
    ST_BOUND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                   en;
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [FILL_W-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                     push;
    logic signed [DATA_W-1:0] value;
  } win_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [FILL_W-1:0]       fill;
  } win_rsp_t;

endpackage

// ===== src/alif_if.sv =====
// Valid/ready channel interfaces of the neuron step block: config, input, output.
// Depends on alif_pkg for field widths.
interface alif_cfg_if import alif_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface alif_in_if import alif_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] summed_input;
  modport source (output valid, summed_input, input ready);
  modport sink   (input valid, summed_input, output ready);
endinterface

interface alif_out_if import alif_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     fired;
  logic signed [DATA_W-1:0] membrane_potential;
  logic [Q_W-1:0]           firing_threshold;
  logic [Q_W-1:0]           adaptation_level;
  logic [Q_W-1:0]           time_since_spike;
  modport source (output valid, fired, membrane_potential, firing_threshold,
                  adaptation_level, time_since_spike, input ready);
  modport sink   (input valid, fired, membrane_potential, firing_threshold,
                  adaptation_level, time_since_spike, output ready);
endinterface

// ===== src/adaptive_lif_neuron_step_top.sv =====
// Adaptive leaky integrate-and-fire neuron, one time step per input request,
// Q16.16 fixed point throughout. Instantiates alif_mul, alif_div and alif_win.
//
// One input request carries the summed synaptic input of a time step; one output
// request reports the spike flag, the potential after the step, the threshold
// for the next step, the adaptation current and the time since the last spike.
// A small sequencer runs each step through a single shared 33x24 signed
// multiplier (leak factor, leaked potential, decay factor, decayed adaptation,
// homeostatic error and lower threshold bound). Once MIN_SAMPLES potentials sit
// in the window, the threshold is re-derived from the window mean at each step,
// which costs a 40-step restoring divide (one quotient bit per cycle).
// The input is ready only in the idle state. The result sits in an output
// register, so the next input request is taken while the previous result
// still waits for the sink.
// Configuration writes are always accepted and must only come while idle; a
// new baseline threshold takes effect at the next threshold update. The window
// memory holds no reset: an entry is only read back once the window is full.
module adaptive_lif_neuron_step_top import alif_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  alif_cfg_if.sink  cfg_i,
  alif_in_if.sink   in_i,
  alif_out_if.source out_o
);

  localparam int unsigned V_W   = PFL_W + 1;
  localparam int unsigned NE_W  = DATA_W + 1;
  localparam int unsigned HI_W  = BASE_W + 4;

  // Configuration registers.
  logic [LEAK_W-1:0] leak_q;
  logic [STEP_W-1:0] step_q;
  logic [KICK_W-1:0] kick_q;
  logic [BASE_W-1:0] base_q;

  // Sequencer and neuron state.
  state_e                   state_q, state_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [MB_W-1:0]   fac_q, fac_d;
  logic signed [DATA_W-1:0] v_q, v_d;
  logic                     fired_q, fired_d;
  logic signed [DATA_W-1:0] pot_q, pot_d;
  logic [Q_W-1:0]           adapt_q, adapt_d;
  logic [Q_W-1:0]           thr_q, thr_d;
  logic [Q_W-1:0]           elapsed_q, elapsed_d;
  logic signed [NE_W-1:0]   nerr_q, nerr_d;
  logic signed [V_W-1:0]    tw_q, tw_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic                     out_fired_q;
  logic signed [DATA_W-1:0] out_pot_q;
  logic [Q_W-1:0]           out_thr_q;
  logic [Q_W-1:0]           out_adapt_q;
  logic [Q_W-1:0]           out_elapsed_q;
  logic                     out_load;

  // Unit links.
  mul_req_t               mul_req;
  logic signed [MP_W-1:0] prod;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  win_req_t               win_req;
  win_rsp_t               win_rsp;

  // Datapath helpers.
  logic signed [PFL_W-1:0] pfl;
  logic signed [MB_W-1:0]  fac_calc;
  logic signed [V_W-1:0]   v_wide;
  logic                    v_in_range;
  logic                    fire;
  logic [DATA_W-1:0]       el_sum;
  logic [DATA_W-1:0]       kick_sum;
  logic [Q_W-1:0]          lo;
  logic [HI_W-1:0]         hi10;
  logic [Q_W-1:0]          hi;

  alif_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  alif_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  alif_win u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (win_req),
    .rsp_o  (win_rsp)
  );

  // Configuration port: every write request is taken at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_q <= LEAK_W'(LEAK_RST);
      step_q <= STEP_W'(STEP_RST);
      kick_q <= KICK_W'(KICK_RST);
      base_q <= BASE_W'(BASE_RST);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_LEAK:       leak_q <= cfg_i.data[LEAK_W-1:0];
        CFG_TIME_STEP:  step_q <= cfg_i.data[STEP_W-1:0];
        CFG_ADAPT_KICK: kick_q <= cfg_i.data[KICK_W-1:0];
        CFG_BASE_THR:   base_q <= cfg_i.data[BASE_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Shared datapath pieces that several states read.
  always_comb begin
    // Product scaled back by 2^16 with floor rounding.
    pfl      = $signed(prod[MP_W-1:FRAC]);
    // 1 - rate*dt, from an unsigned rate*dt product.
    fac_calc = MB_W'(ONE_Q) - MB_W'(prod[FRAC +: SCL_W]);
    // Leaked potential plus input minus adaptation, before saturation.
    v_wide   = V_W'(pfl) + V_W'(x_q) - $signed(V_W'(adapt_q));
    v_in_range = (&v_wide[V_W-1:DATA_W-1]) || !(|v_wide[V_W-1:DATA_W-1]);
    fire     = v_q > $signed({1'b0, thr_q});
    el_sum   = {1'b0, elapsed_q} + DATA_W'(step_q);
    kick_sum = {1'b0, adapt_q} + {1'b0, kick_q};
    lo       = prod[FRAC +: Q_W];
    hi10     = HI_W'({base_q, 3'b000}) + HI_W'({base_q, 1'b0});
    hi       = (hi10 > HI_W'(MAX_Q)) ? MAX_Q : hi10[Q_W-1:0];
  end

  // Sequencer: next state, unit requests and register updates.
  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    fac_d     = fac_q;
    v_d       = v_q;
    fired_d   = fired_q;
    pot_d     = pot_q;
    adapt_d   = adapt_q;
    thr_d     = thr_q;
    elapsed_d = elapsed_q;
    nerr_d    = nerr_q;
    tw_d      = tw_q;
    out_load  = 1'b0;

    mul_req         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = win_rsp.sum;
    div_req.divisor  = win_rsp.fill;
    win_req.push     = 1'b0;
    win_req.value    = v_q;
    in_i.ready       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          x_d     = in_i.summed_input;
          state_d = ST_LEAK_MUL;
        end
      end
      ST_LEAK_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MA_W'(leak_q);
        mul_req.b  = MB_W'(step_q);
        state_d    = ST_LEAK_FAC;
      end
      ST_LEAK_FAC: begin
        fac_d   = fac_calc;
        state_d = ST_POT_MUL;
      end
      ST_POT_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MA_W'(pot_q);
        mul_req.b  = fac_q;
        state_d    = ST_POT_SUM;
      end
      ST_POT_SUM: begin
        // Saturate the new potential to 32 bits.
        if (v_in_range) begin
          v_d = v_wide[DATA_W-1:0];
        end else if (v_wide[V_W-1]) begin
          v_d = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          v_d = {1'b0, {(DATA_W-1){1'b1}}};
        end
        state_d = ST_FIRE;
      end
      ST_FIRE: begin
        // Record the pre-reset potential, then spike against the old threshold.
        win_req.push = 1'b1;
        fired_d      = fire;
        if (fire) begin
          pot_d     = '0;
          elapsed_d = '0;
          adapt_d   = kick_sum[DATA_W-1] ? MAX_Q : kick_sum[Q_W-1:0];
        end else begin
          pot_d     = v_q;
          elapsed_d = el_sum[DATA_W-1] ? MAX_Q : el_sum[Q_W-1:0];
        end
        state_d = ST_DEC_MUL;
      end
      ST_DEC_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MA_W'(step_q);
        mul_req.b  = MB_W'(TENTH_Q);
        state_d    = ST_DEC_FAC;
      end
      ST_DEC_FAC: begin
        fac_d   = fac_calc;
        state_d = ST_ADAPT_MUL;
      end
      ST_ADAPT_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MA_W'(adapt_q);
        mul_req.b  = fac_q;
        state_d    = ST_ADAPT;
      end
      ST_ADAPT: begin
        // Clamp the decayed adaptation to [0, 2^31-1].
        if (pfl[PFL_W-1]) begin
          adapt_d = '0;
        end else if (|pfl[PFL_W-2:Q_W]) begin
          adapt_d = MAX_Q;
        end else begin
          adapt_d = pfl[Q_W-1:0];
        end
        if (win_rsp.fill >= FILL_W'(MIN_SAMPLES)) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV_WAIT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        // Negated error: baseline/2 - mean.
        nerr_d  = NE_W'({2'b00, base_q[BASE_W-1:1]}) - NE_W'(div_rsp.quotient);
        state_d = ST_ERR_MUL;
      end
      ST_ERR_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MA_W'(nerr_q);
        mul_req.b  = MB_W'(HUNDREDTH_Q);
        state_d    = ST_THR;
      end
      ST_THR: begin
        tw_d       = $signed(V_W'(base_q)) + V_W'(pfl);
        mul_req.en = 1'b1;
        mul_req.a  = MA_W'(base_q);
        mul_req.b  = MB_W'(TENTH_Q);
        state_d    = ST_BOUND;
      end
      ST_BOUND: begin
        // Hold the threshold within [0.1, 10] times baseline.
        if (tw_q < $signed({{(V_W-Q_W){1'b0}}, lo})) begin
          thr_d = lo;
        end else if (tw_q > $signed({{(V_W-Q_W){1'b0}}, hi})) begin
          thr_d = hi;
        end else begin
          thr_d = tw_q[Q_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Advance once the output register is free or being drained.
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pot_q       <= '0;
      adapt_q     <= '0;
      thr_q       <= Q_W'(BASE_RST);
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pot_q       <= pot_d;
      adapt_q     <= adapt_d;
      thr_q       <= thr_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    fac_q   <= fac_d;
    v_q     <= v_d;
    fired_q <= fired_d;
    nerr_q  <= nerr_d;
    tw_q    <= tw_d;
    if (out_load) begin
      out_fired_q   <= fired_q;
      out_pot_q     <= pot_q;
      out_thr_q     <= thr_q;
      out_adapt_q   <= adapt_q;
      out_elapsed_q <= elapsed_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.fired              = out_fired_q;
  assign out_o.membrane_potential = out_pot_q;
  assign out_o.firing_threshold   = out_thr_q;
  assign out_o.adaptation_level   = out_adapt_q;
  assign out_o.time_since_spike   = out_elapsed_q;

  spike_resets_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.fired) |->
      (out_o.membrane_potential == '0 && out_o.time_since_spike == '0))
    else $error("spike result without potential and timer reset");

  div_needs_samples_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (win_rsp.fill >= FILL_W'(MIN_SAMPLES) && state_q == ST_ADAPT))
    else $error("mean requested with too few samples");

  accept_starts_step_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_LEAK_MUL && !$stable(state_q)))
    else $error("accepted request did not start a step");

endmodule

// ===== src/alif_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on alif_pkg for operand widths and the request struct.
module alif_mul import alif_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mul_req_t               req_i,
  output logic signed [MP_W-1:0] prod_o
);

  logic signed [MP_W-1:0] a_ext;
  logic signed [MP_W-1:0] b_ext;
  logic signed [MP_W-1:0] prod_q;
  logic                   seen_q;

  assign a_ext  = MP_W'(req_i.a);
  assign b_ext  = MP_W'(req_i.b);
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= a_ext * b_ext;
    end
  end

  // Track that a product was ever captured (for the check below).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (req_i.en) begin
      seen_q <= 1'b1;
    end
  end

  prod_known_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.en |=> seen_q)
    else $error("multiplier product not captured");

endmodule

// ===== src/alif_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Divides the signed window sum by the unsigned fill count; uses alif_pkg.
module alif_div import alif_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic [FILL_W-1:0] dvs_q;
  logic              neg_q;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;
  logic              ge;
  logic [SUM_W-1:0]  quo_sgn;

  always_comb begin
    trial  = {rem_q, quo_q[SUM_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // Work on the magnitude, fix the sign at the end.
      quo_d  = req_i.dividend[SUM_W-1] ? SUM_W'(-req_i.dividend) : SUM_W'(req_i.dividend);
      rem_d  = '0;
      cnt_d  = CNT_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[SUM_W-2:0], ge};
      rem_d = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    quo_sgn = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = $signed(quo_sgn[DATA_W-1:0]);

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
      neg_q <= req_i.dividend[SUM_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  start_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  done_after_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a finished run");

endmodule

// ===== src/alif_win.sv =====
// Sliding window of recent potentials with running sum, fill count and pointer.
// Holds the window memory; depends on alif_pkg for depth and widths.
module alif_win import alif_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  win_req_t req_i,
  output win_rsp_t rsp_o
);

  logic signed [DATA_W-1:0] mem [WINDOW_LEN];
  logic signed [DATA_W-1:0] rd_q;
  logic [PTR_W-1:0]         ptr_q, ptr_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     full;

  // Read the oldest entry ahead of time; the pointer is settled long before a push.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[ptr_q] <= req_i.value;
    end
    rd_q <= mem[ptr_q];
  end

  always_comb begin
    full   = (fill_q == FILL_W'(WINDOW_LEN));
    ptr_d  = ptr_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (req_i.push) begin
      sum_d = sum_q + SUM_W'(req_i.value);
      if (full) begin
        sum_d = sum_q + SUM_W'(req_i.value) - SUM_W'(rd_q);
      end else begin
        fill_d = fill_q + 1'b1;
      end
      ptr_d = (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  assign rsp_o.sum  = sum_q;
  assign rsp_o.fill = fill_q;

  fill_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= FILL_W'(WINDOW_LEN)) && (!full || ptr_q < PTR_W'(WINDOW_LEN)))
    else $error("window fill or pointer out of range");

endmodule
